// ===== hw/rtl/sprq_pkg.sv =====
package sprq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int ID_W = 16;
  localparam int PRIO_W = 4;
  localparam int OCC_W = 5;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    proc_id;
    logic [PRIO_W-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    out_id;
    logic [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]   occupancy;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

// ===== hw/rtl/stable_priority_ready_queue_core.sv =====
// Stable priority ready queue: enqueue requests (in_tuser = 0) insert a process id
// behind every stored entry of equal or higher priority; dequeue requests
// (in_tuser = 1) pop the head. Each request gives one result with status, the
// popped entry and the occupancy. Entries sit in a circular buffer with one
// write and one registered read a cycle, walked by a small sequencer.
// A dequeue reads the head, then registers the popped entry and advances the
// head. An enqueue walks from the tail toward the head, reading and comparing
// the entry in front of the free slot; one of lower priority is written one
// slot back, and the new entry is written where a stored entry of equal or
// higher priority stops the walk, or at the head. A rejected request (empty or
// full) goes straight to the result. in_tready returns once the sequencer has
// handed off its result. Each result then passes an output register, and the
// next request is taken while a result waits there; the sequencer holds its
// own result while that register is still full.
module stable_priority_ready_queue_core import sprq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // proc_id[15:0], priority_req[19:16], zero pad
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_id[15:0], out_priority[19:16],
                                  // occupancy[24:20], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  req_t  req;
  res_t  eng_res;
  logic  eng_res_valid;
  logic  eng_res_ready;
  logic  out_valid_r;
  res_t  out_res_r;

  assign req.kind = kind_t'(in_tuser[0]);
  assign req.proc_id = in_tdata[15:0];
  assign req.priority_req = in_tdata[19:16];

  sprq_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req(req),
    .res_valid(eng_res_valid),
    .res_ready(eng_res_ready),
    .res(eng_res)
  );

  assign eng_res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid_r <= eng_res_valid;
      if (eng_res_valid) begin
        out_res_r <= eng_res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_res_r.status;
  assign out_tdata = {7'd0, out_res_r.occupancy, out_res_r.out_priority, out_res_r.out_id};

endmodule

// ===== hw/rtl/sprq_engine.sv =====
module sprq_engine import sprq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_DEQ_OUT,
    S_FIN
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   head_r;
  logic [AW-1:0]   idx_r;
  req_t            req_r;
  status_t         st_r;
  entry_t          out_ent_r;

  entry_t          mem [DEPTH];
  entry_t          rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            move;
  entry_t          new_ent;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign new_ent = '{id: req_r.proc_id, prio: req_r.priority_req};
  assign move = (rd_q.prio < req_r.priority_req);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.status = st_r;
  assign res.out_id = out_ent_r.id;
  assign res.out_priority = out_ent_r.prio;
  assign res.occupancy = OCC_W'(cnt_r);

  always_comb begin
    rd_addr = head_r;
    wr_en = 1'b0;
    wr_addr = phys(head_r, idx_r);
    wr_data = new_ent;
    unique case (state_r)
      S_ENQ_RD: begin
        if (idx_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = phys(head_r, idx_r - AW'(1));
        end
      end
      S_ENQ_CMP: begin
        wr_en = 1'b1;
        if (move) begin
          wr_data = rd_q;
        end
      end
      S_IDLE, S_DEQ_OUT, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      head_r <= '0;
      idx_r <= '0;
      st_r <= ST_OK;
      out_ent_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            out_ent_r <= '0;
            st_r <= ST_OK;
            if (req.kind == KIND_ENQ) begin
              if (cnt_r == DEPTH_C) begin
                st_r <= ST_FULL;
                state_r <= S_FIN;
              end else begin
                idx_r <= cnt_r[AW-1:0];
                state_r <= S_ENQ_RD;
              end
            end else begin
              if (cnt_r == '0) begin
                st_r <= ST_EMPTY;
                state_r <= S_FIN;
              end else begin
                state_r <= S_DEQ_OUT;
              end
            end
          end
        end
        S_ENQ_RD: begin
          if (idx_r == '0) begin
            cnt_r <= cnt_r + CW'(1);
            state_r <= S_FIN;
          end else begin
            state_r <= S_ENQ_CMP;
          end
        end
        S_ENQ_CMP: begin
          if (move) begin
            idx_r <= idx_r - AW'(1);
            state_r <= S_ENQ_RD;
          end else begin
            cnt_r <= cnt_r + CW'(1);
            state_r <= S_FIN;
          end
        end
        S_DEQ_OUT: begin
          out_ent_r <= rd_q;
          head_r <= phys(head_r, AW'(1));
          cnt_r <= cnt_r - CW'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ_OUT) |-> (cnt_r != '0))
    else $error("dequeue read on empty queue");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_FULL) |-> (cnt_r == DEPTH_C))
    else $error("full status while not full");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENQ_CMP && !move) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not advance count");
`endif

endmodule
